FILE: rtl/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define SSFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SSFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssfl_pkg.sv
package ssfl_pkg;

  localparam int PatternMax = 16;
  localparam int RegionMax  = 65536;

  localparam int ByteW   = 8;
  localparam int WordW   = 64;
  localparam int LenW    = 5;
  localparam int OffsetW = 16;
  localparam int StartW  = 16;
  localparam int PosW    = 17;
  localparam int SeenW   = $clog2(RegionMax) + 1;
  localparam int IdxW    = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_PAT_LEN = 3'd2,
    CFG_DIR     = 3'd3,
    CFG_OFFSET  = 3'd4
  } cfg_idx_e;

  typedef logic [ByteW-1:0] byte_t;

endpackage

FILE: rtl/ssfl_if.sv
interface ssfl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssfl_pkg::CfgIdxW-1:0]   index;
  logic [ssfl_pkg::WordW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface ssfl_in_if;
  logic                 valid;
  logic                 ready;
  ssfl_pkg::byte_t      text_byte;
  logic                 region_end;

  modport source (output valid, output text_byte, output region_end, input ready);
  modport sink   (input valid, input text_byte, input region_end, output ready);
endinterface

interface ssfl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ssfl_pkg::PosW-1:0]  match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

FILE: rtl/substring_search_first_last.sv
// Channel   Dir  Payload                      Note
// cfg_i     in   index[2:0], data[63:0]       always ready, takes effect next cycle
// text_i    in   text_byte[7:0], region_end   one byte per item
// result_o  out  found, match_position[16:0]  one item per region, registered
//
// One byte per cycle; the window shift and 16-way compare finish in the accept cycle.
// The result item appears in the output register the cycle after the closing byte.
// Reset clears the window, counters and output valid; pattern length resets to 1.
// Input is stalled only while a result sits unread in the output register.
`include "assert_macros.svh"

module substring_search_first_last (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssfl_cfg_if.sink   cfg_i,
  ssfl_in_if.sink    text_i,
  ssfl_out_if.source result_o
);

  logic [ssfl_pkg::WordW-1:0]   pat_lo_q, pat_hi_q;
  logic [ssfl_pkg::LenW-1:0]    len_q;
  logic                         dir_q;
  logic [ssfl_pkg::OffsetW-1:0] offset_q;

  ssfl_pkg::byte_t              win_q [ssfl_pkg::PatternMax];
  ssfl_pkg::byte_t              win_d [ssfl_pkg::PatternMax];
  ssfl_pkg::byte_t              win_sh [ssfl_pkg::PatternMax];
  logic [ssfl_pkg::SeenW-1:0]   seen_q, seen_d, seen_inc;
  logic                         have_q, have_d;
  logic [ssfl_pkg::StartW-1:0]  mstart_q, mstart_d, new_start;

  logic                         out_valid_q, out_valid_d;
  logic                         out_found_q, out_found_d;
  logic [ssfl_pkg::PosW-1:0]    out_pos_q, out_pos_d;

  logic [2*ssfl_pkg::WordW-1:0] pat_all;
  logic                         in_fire, active, len_ok, long_enough, win_hit, hit, take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= ssfl_pkg::LenW'(1);
      dir_q    <= 1'b0;
      offset_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ssfl_pkg::CFG_PAT_LO:  pat_lo_q <= cfg_i.data;
        ssfl_pkg::CFG_PAT_HI:  pat_hi_q <= cfg_i.data;
        ssfl_pkg::CFG_PAT_LEN: len_q    <= cfg_i.data[ssfl_pkg::LenW-1:0];
        ssfl_pkg::CFG_DIR:     dir_q    <= cfg_i.data[0];
        ssfl_pkg::CFG_OFFSET:  offset_q <= cfg_i.data[ssfl_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire      = text_i.valid && text_i.ready;
  assign text_i.ready = !out_valid_q || result_o.ready;

  assign pat_all  = {pat_hi_q, pat_lo_q};
  assign active   = seen_q < ssfl_pkg::SeenW'(ssfl_pkg::RegionMax);
  assign seen_inc = seen_q + ssfl_pkg::SeenW'(1);
  assign len_ok   = (len_q != '0) && (len_q <= ssfl_pkg::LenW'(ssfl_pkg::PatternMax));
  assign long_enough = seen_inc >= ssfl_pkg::SeenW'(len_q);
  assign new_start   = ssfl_pkg::StartW'(seen_inc - ssfl_pkg::SeenW'(len_q));

  // win_sh[0] is the newest byte; entry j lines up with pattern byte len-1-j
  always_comb begin
    logic [ssfl_pkg::IdxW-1:0] idx;
    win_sh[0] = text_i.text_byte;
    for (int j = 1; j < ssfl_pkg::PatternMax; j++) begin
      win_sh[j] = win_q[j-1];
    end
    win_hit = 1'b1;
    for (int j = 0; j < ssfl_pkg::PatternMax; j++) begin
      idx = ssfl_pkg::IdxW'(len_q - ssfl_pkg::LenW'(1) - ssfl_pkg::LenW'(j));
      if (ssfl_pkg::LenW'(j) < len_q &&
          win_sh[j] != pat_all[{idx, 3'b000} +: ssfl_pkg::ByteW]) begin
        win_hit = 1'b0;
      end
    end
  end

  assign hit  = active && len_ok && long_enough && win_hit;
  assign take = hit && (dir_q || !have_q);

  always_comb begin
    logic                      have_nxt;
    logic [ssfl_pkg::StartW-1:0] mstart_nxt;
    have_nxt    = have_q || take;
    mstart_nxt  = take ? new_start : mstart_q;

    win_d       = win_q;
    seen_d      = seen_q;
    have_d      = have_q;
    mstart_d    = mstart_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_valid_d = out_valid_q && !result_o.ready;

    if (in_fire) begin
      if (text_i.region_end) begin
        for (int j = 0; j < ssfl_pkg::PatternMax; j++) begin
          win_d[j] = '0;
        end
        seen_d      = '0;
        have_d      = 1'b0;
        mstart_d    = '0;
        out_valid_d = 1'b1;
        out_found_d = have_nxt;
        out_pos_d   = have_nxt ? ({1'b0, offset_q} + {1'b0, mstart_nxt}) : '0;
      end else if (active) begin
        win_d    = win_sh;
        seen_d   = seen_inc;
        have_d   = have_nxt;
        mstart_d = mstart_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ssfl_pkg::PatternMax; j++) begin
        win_q[j] <= '0;
      end
      seen_q      <= '0;
      have_q      <= 1'b0;
      mstart_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      have_q      <= have_d;
      mstart_q    <= mstart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.found          = out_found_q;
  assign result_o.match_position = out_pos_q;

  `SSFL_ASSERT_IMP(a_miss_pos_zero, result_o.valid && !result_o.found, result_o.match_position == '0, "miss with nonzero position")
  `SSFL_ASSERT_NXT(a_end_gives_result, in_fire && text_i.region_end, result_o.valid, "closing byte gave no result")
  `SSFL_ASSERT_NXT(a_end_clears, in_fire && text_i.region_end, seen_q == '0 && !have_q, "region state not cleared")
  `SSFL_ASSERT(a_seen_bound, seen_q <= ssfl_pkg::SeenW'(ssfl_pkg::RegionMax), "byte count past region limit")

endmodule
